// ----- rtl/packet_header_parser_defines.svh -----
// ---------------------------------------------------------------------------
// packet header parser assertion macros
// shared helpers for concurrent checks on clk / arst_n
// ---------------------------------------------------------------------------
`ifndef PACKET_HEADER_PARSER_DEFINES_SVH
`define PACKET_HEADER_PARSER_DEFINES_SVH

// same-cycle implication
`define PHP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("php check failed");

// next-cycle implication
`define PHP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("php check failed");

`endif

// ----- rtl/php_pkg.sv -----
// ---------------------------------------------------------------------------
// php_pkg
// shared types and codes for the packet header parser
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package php_pkg;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TRUNC     = 3'd1;
	localparam logic [2:0] ST_BAD_ETYPE = 3'd2;
	localparam logic [2:0] ST_BAD_IPVER = 3'd3;
	localparam logic [2:0] ST_BAD_NEXT  = 3'd4;

	localparam logic [1:0] L3_NONE = 2'd0;
	localparam logic [1:0] L3_IPV4 = 2'd1;
	localparam logic [1:0] L3_IPV6 = 2'd2;

	localparam logic [1:0] L4_NONE = 2'd0;
	localparam logic [1:0] L4_TCP  = 2'd1;
	localparam logic [1:0] L4_UDP  = 2'd2;

	localparam logic [15:0] ETYPE_VLAN = 16'h8100;
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;
	localparam logic [7:0] NH_HOPOPT  = 8'd0;
	localparam logic [7:0] NH_ROUTING = 8'd43;
	localparam logic [7:0] NH_FRAG    = 8'd44;
	localparam logic [7:0] NH_DSTOPT  = 8'd60;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  l3_kind;
		logic [1:0]  l4_kind;
		logic [63:0] source_high;
		logic [63:0] source_low;
		logic [63:0] dest_high;
		logic [63:0] dest_low;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [3:0]  tcp_flags;
		logic [15:0] tcp_window;
		logic [15:0] ip_length;
	} php_result_t;

endpackage

// ----- rtl/packet_header_parser.sv -----
// ---------------------------------------------------------------------------
// packet_header_parser
// streaming ethernet / vlan / ipv4 / ipv6 / tcp / udp header parser
// ---------------------------------------------------------------------------
// Takes one packet byte per transaction in wire order and returns one result
// transaction on the byte marked is_last. A byte is taken into an input
// register, the parse state is updated from it, and for the last
// byte the summary is loaded into the result register. A new byte is taken
// every cycle; the input stalls only while a finished result waits behind a
// last byte and the output side holds off. The result is valid once the
// last byte leaves the input register. The byte counter saturates at MAX_PACKET_BYTES.
`timescale 1ns / 1ps
`include "packet_header_parser_defines.svh"

module packet_header_parser import php_pkg::*; #(
	parameter int MAX_PACKET_BYTES = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [1:0]  l3_kind,
	output logic [1:0]  l4_kind,
	output logic [63:0] source_high,
	output logic [63:0] source_low,
	output logic [63:0] dest_high,
	output logic [63:0] dest_low,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [3:0]  tcp_flags,
	output logic [15:0] tcp_window,
	output logic [15:0] ip_length
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        out_free, consume, step;
	php_result_t res, res_q;
	logic        out_valid_q;

	// result register free this cycle
	assign out_free = !out_valid_q || out_ready;
	// stage 1 moves on unless a last byte has nowhere to put its result
	assign consume  = !last_s1 || out_free;
	assign step     = valid_s1 && consume;
	assign in_ready = !valid_s1 || consume;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			last_s1  <= is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) byte_s1 <= data_byte;
	end

	php_engine #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.data_byte(byte_s1),
		.is_last  (last_s1),
		.result   (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) res_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign status      = res_q.status;
	assign l3_kind     = res_q.l3_kind;
	assign l4_kind     = res_q.l4_kind;
	assign source_high = res_q.source_high;
	assign source_low  = res_q.source_low;
	assign dest_high   = res_q.dest_high;
	assign dest_low    = res_q.dest_low;
	assign source_port = res_q.source_port;
	assign dest_port   = res_q.dest_port;
	assign tcp_flags   = res_q.tcp_flags;
	assign tcp_window  = res_q.tcp_window;
	assign ip_length   = res_q.ip_length;

	// a fresh result only ever follows a last byte leaving stage 1
	`PHP_ASSERT_IMPL(a_rise_from_last, $rose(out_valid_q), $past(valid_s1 && last_s1))
	// status code stays within the defined set
	`PHP_ASSERT_IMPL(a_status_range, out_valid_q, res_q.status <= ST_BAD_NEXT)
	// no layer 3 means the low source address and ip length read zero
	`PHP_ASSERT_IMPL(a_no_l3_zero, out_valid_q && res_q.l3_kind == L3_NONE,
		res_q.source_low == '0 && res_q.ip_length == '0)
	// tcp-only fields clear for anything else
	`PHP_ASSERT_IMPL(a_tcp_only, out_valid_q && res_q.l4_kind != L4_TCP,
		res_q.tcp_flags == '0 && res_q.tcp_window == '0)
	// a stalled last byte holds stage 1
	`PHP_ASSERT_NEXT(a_hold_last, valid_s1 && last_s1 && !out_free, valid_s1 && last_s1)

endmodule

// ----- rtl/php_engine.sv -----
// ---------------------------------------------------------------------------
// php_engine
// per-packet parse state and the combinational byte update
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module php_engine import php_pkg::*; #(
	parameter int MAX_PACKET_BYTES = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        is_last,
	output php_result_t result
);

	typedef enum logic [3:0] {
		PH_ETH, PH_VLAN, PH_IPV4, PH_IPV6, PH_EXT,
		PH_FRAG, PH_SKIP, PH_TCP, PH_UDP, PH_DONE
	} phase_t;

	localparam logic [16:0] MAX_B = 17'(MAX_PACKET_BYTES);

	logic [15:0] pos_q, hstart_q, hend_q, ntype_q, len_q, win_q, sport_q, dport_q;
	logic [63:0] addr_q [4];
	logic [3:0]  flags_q;
	logic [7:0]  ks_q;
	phase_t      phase_q;

	logic [15:0] pos_n, hstart_n, hend_n, ntype_n, len_n, win_n, sport_n, dport_n;
	logic [63:0] addr_n [4];
	logic [3:0]  flags_n;
	logic [7:0]  ks_n;
	phase_t      phase_n;

	always_comb begin
		logic [15:0] rel, rel8;
		logic [16:0] start, ext_end, hdr_end;
		logic [5:0]  hlen, blen;
		logic        abort, do_l4, do_beg, do_fin;
		logic [2:0]  fcode;
		logic [3:0]  ihl;
		phase_t      bph;

		pos_n = pos_q; hstart_n = hstart_q; hend_n = hend_q; ntype_n = ntype_q;
		len_n = len_q; win_n = win_q; sport_n = sport_q; dport_n = dport_q;
		addr_n = addr_q; flags_n = flags_q; ks_n = ks_q; phase_n = phase_q;
		rel = pos_q - hstart_q;
		rel8 = rel - 16'd8;
		start = 17'(pos_q) + 17'd1;
		ext_end = 17'(hstart_q) + ((17'(data_byte) + 17'd1) << 3);
		hdr_end = '0; hlen = '0; blen = '0; ihl = '0;
		abort = 1'b0; do_l4 = 1'b0; do_beg = 1'b0; do_fin = 1'b0;
		fcode = ST_OK; bph = PH_DONE;

		if (17'(pos_q) < MAX_B) begin
			case (phase_q)
				PH_ETH: if (rel >= 16'd12) ntype_n = {ntype_q[7:0], data_byte};
				PH_VLAN: if (rel >= 16'd2) ntype_n = {ntype_q[7:0], data_byte};
				PH_IPV4: begin
					if (rel == 16'd0) begin
						if (data_byte[7:4] != 4'd4) ks_n[7] = 1'b1;
						flags_n = data_byte[3:0];
					end else if (rel == 16'd2 || rel == 16'd3) begin
						len_n = {len_q[7:0], data_byte};
					end else if (rel == 16'd9) begin
						ntype_n = {8'd0, data_byte};
					end else if (rel >= 16'd12 && rel < 16'd16) begin
						addr_n[1] = {32'd0, addr_q[1][23:0], data_byte};
					end else if (rel >= 16'd16 && rel < 16'd20) begin
						addr_n[3] = {32'd0, addr_q[3][23:0], data_byte};
					end
				end
				PH_IPV6: begin
					if (rel == 16'd0) begin
						if (data_byte[7:4] != 4'd6) ks_n[7] = 1'b1;
					end else if (rel == 16'd4 || rel == 16'd5) begin
						len_n = {len_q[7:0], data_byte};
					end else if (rel == 16'd6) begin
						ntype_n = {8'd0, data_byte};
					end else if (rel >= 16'd8 && rel < 16'd40) begin
						addr_n[rel8[4:3]] = {addr_q[rel8[4:3]][55:0], data_byte};
					end
				end
				PH_EXT: begin
					if (rel == 16'd0) begin
						ntype_n = {8'd0, data_byte};
					end else if (rel == 16'd1) begin
						if (ext_end > MAX_B) begin
							ks_n = (ks_q & 8'h78) | 8'(ST_TRUNC);
							phase_n = PH_DONE;
							abort = 1'b1;
						end else begin
							hend_n = ext_end[15:0];
						end
					end
				end
				PH_FRAG: if (rel == 16'd0) ntype_n = {8'd0, data_byte};
				PH_TCP: begin
					if (rel < 16'd4) begin
						if (rel[1]) dport_n = {dport_q[7:0], data_byte};
						else        sport_n = {sport_q[7:0], data_byte};
					end else if (rel == 16'd13) begin
						flags_n = {data_byte[4], data_byte[1], data_byte[2], data_byte[0]};
					end else if (rel == 16'd14 || rel == 16'd15) begin
						win_n = {win_q[7:0], data_byte};
					end
				end
				PH_UDP: begin
					if (rel < 16'd4) begin
						if (rel[1]) dport_n = {dport_q[7:0], data_byte};
						else        sport_n = {sport_q[7:0], data_byte};
					end
				end
				default: abort = 1'b1;
			endcase

			// header complete: decide what follows
			if (!abort && phase_n != PH_DONE && start == 17'(hend_n)) begin
				case (phase_q)
					PH_ETH, PH_VLAN: begin
						if (ntype_n == ETYPE_VLAN) begin
							do_beg = 1'b1; bph = PH_VLAN; blen = 6'd4;
						end else if (ntype_n == ETYPE_IPV4) begin
							do_beg = 1'b1; bph = PH_IPV4; blen = 6'd20;
						end else if (ntype_n == ETYPE_IPV6) begin
							do_beg = 1'b1; bph = PH_IPV6; blen = 6'd40;
						end else begin
							do_fin = 1'b1; fcode = ST_BAD_ETYPE;
						end
					end
					PH_IPV4: begin
						if (ks_n[7]) begin
							do_fin = 1'b1; fcode = ST_BAD_IPVER;
						end else begin
							ks_n[4:3] = ks_n[4:3] | L3_IPV4;
							if (ntype_n != 16'(PROTO_TCP) && ntype_n != 16'(PROTO_UDP)) begin
								do_fin = 1'b1; fcode = ST_BAD_NEXT;
							end else begin
								ihl = (flags_n < 4'd5) ? 4'd5 : flags_n;
								hlen = {ihl, 2'b00};
								if (hlen > 6'd20) begin
									do_beg = 1'b1; bph = PH_SKIP; blen = hlen - 6'd20;
								end else begin
									do_l4 = 1'b1;
								end
							end
						end
					end
					PH_IPV6, PH_EXT, PH_FRAG: begin
						if (phase_q == PH_IPV6 && ks_n[7]) begin
							do_fin = 1'b1; fcode = ST_BAD_IPVER;
						end else begin
							if (phase_q == PH_IPV6) ks_n[4:3] = ks_n[4:3] | L3_IPV6;
							if (ntype_n == 16'(PROTO_TCP) || ntype_n == 16'(PROTO_UDP)) begin
								do_l4 = 1'b1;
							end else if (ntype_n == 16'(NH_HOPOPT) ||
									ntype_n == 16'(NH_ROUTING) ||
									ntype_n == 16'(NH_DSTOPT)) begin
								do_beg = 1'b1; bph = PH_EXT; blen = 6'd8;
							end else if (ntype_n == 16'(NH_FRAG)) begin
								do_beg = 1'b1; bph = PH_FRAG; blen = 6'd8;
							end else begin
								do_fin = 1'b1; fcode = ST_BAD_NEXT;
							end
						end
					end
					PH_SKIP: do_l4 = 1'b1;
					PH_TCP: begin
						ks_n[6:5] = ks_n[6:5] | L4_TCP;
						do_fin = 1'b1; fcode = ST_OK;
					end
					PH_UDP: begin
						ks_n[6:5] = ks_n[6:5] | L4_UDP;
						do_fin = 1'b1; fcode = ST_OK;
					end
					default: phase_n = PH_DONE;
				endcase

				if (do_l4) begin
					flags_n = '0;
					if (ntype_n == 16'(PROTO_TCP)) begin
						do_beg = 1'b1; bph = PH_TCP; blen = 6'd20;
					end else if (ntype_n == 16'(PROTO_UDP)) begin
						do_beg = 1'b1; bph = PH_UDP; blen = 6'd8;
					end else begin
						do_fin = 1'b1; fcode = ST_BAD_NEXT;
					end
				end
				if (do_beg) begin
					hdr_end = start + 17'(blen);
					if (hdr_end > MAX_B) begin
						do_fin = 1'b1; fcode = ST_TRUNC;
					end else begin
						phase_n = bph;
						hstart_n = start[15:0];
						hend_n = hdr_end[15:0];
					end
				end
				if (do_fin) begin
					ks_n = (ks_n & 8'h78) | 8'(fcode);
					phase_n = PH_DONE;
				end
			end
			pos_n = start[15:0];
		end
	end

	// result as seen after this byte
	always_comb begin
		logic l3v, l4v, tcp;
		l3v = (ks_n[4:3] != L3_NONE);
		l4v = (ks_n[6:5] != L4_NONE);
		tcp = (ks_n[6:5] == L4_TCP);
		result.status      = (phase_n == PH_DONE) ? ks_n[2:0] : ST_TRUNC;
		result.l3_kind     = ks_n[4:3];
		result.l4_kind     = ks_n[6:5];
		result.source_high = l3v ? addr_n[0] : '0;
		result.source_low  = l3v ? addr_n[1] : '0;
		result.dest_high   = l3v ? addr_n[2] : '0;
		result.dest_low    = l3v ? addr_n[3] : '0;
		result.source_port = l4v ? sport_n : '0;
		result.dest_port   = l4v ? dport_n : '0;
		result.tcp_flags   = tcp ? flags_n : '0;
		result.tcp_window  = tcp ? win_n : '0;
		result.ip_length   = l3v ? len_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; hstart_q <= '0; hend_q <= 16'd14; ntype_q <= '0;
			len_q <= '0; win_q <= '0; sport_q <= '0; dport_q <= '0;
			addr_q <= '{default: '0}; flags_q <= '0; ks_q <= '0; phase_q <= PH_ETH;
		end else if (step) begin
			if (is_last) begin
				pos_q <= '0; hstart_q <= '0; hend_q <= 16'd14; ntype_q <= '0;
				len_q <= '0; win_q <= '0; sport_q <= '0; dport_q <= '0;
				addr_q <= '{default: '0}; flags_q <= '0; ks_q <= '0; phase_q <= PH_ETH;
			end else begin
				pos_q <= pos_n; hstart_q <= hstart_n; hend_q <= hend_n;
				ntype_q <= ntype_n; len_q <= len_n; win_q <= win_n;
				sport_q <= sport_n; dport_q <= dport_n; addr_q <= addr_n;
				flags_q <= flags_n; ks_q <= ks_n; phase_q <= phase_n;
			end
		end
	end

endmodule
